// ----- rtl/core/ssd_fmt_pkg.sv -----
`default_nettype none

package ssd_fmt_pkg;

    localparam int DIGITS = 8;
    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int POS_W = $clog2(((DIGITS > 12) ? DIGITS : 12) + 1);
    localparam int OUT_DIGITS = 8;
    localparam int OUT_SHOWN = (DIGITS < OUT_DIGITS) ? DIGITS : OUT_DIGITS;

    localparam int KIND_W = 3;
    localparam int NUM_W = 16;
    localparam int SID_W = 5;
    localparam int DPOS_W = 3;
    localparam int SEG_W = 8 * OUT_DIGITS;
    localparam int BCD_W = 20;
    localparam int WORDS = 28;
    localparam int SYMS = 5;

    localparam logic [KIND_W-1:0] KIND_NUM4 = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NUM3 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUM2 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WORD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DOT  = 3'd4;

    localparam logic [7:0] SYM_DOT = 8'h80;

    localparam logic [7:0] G0    = 8'h3F;
    localparam logic [7:0] G1    = 8'h06;
    localparam logic [7:0] G5    = 8'h6D;
    localparam logic [7:0] GA    = 8'h77;
    localparam logic [7:0] GC    = 8'h39;
    localparam logic [7:0] GD    = 8'h7C;
    localparam logic [7:0] GE    = 8'h79;
    localparam logic [7:0] GF    = 8'h71;
    localparam logic [7:0] GG    = 8'h3D;
    localparam logic [7:0] GH    = 8'h76;
    localparam logic [7:0] GL    = 8'h38;
    localparam logic [7:0] GN    = 8'h54;
    localparam logic [7:0] GP    = 8'h73;
    localparam logic [7:0] GR    = 8'h50;
    localparam logic [7:0] GT    = 8'h78;
    localparam logic [7:0] GU    = 8'h3E;
    localparam logic [7:0] GB    = 8'h00;
    localparam logic [7:0] GBAR3 = 8'h49;
    localparam logic [7:0] GBAR2 = 8'h48;
    localparam logic [7:0] GLOW  = 8'h08;
    localparam logic [7:0] GDEG  = 8'h63;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0: g = 8'h3F;
            4'd1: g = 8'h06;
            4'd2: g = 8'h5B;
            4'd3: g = 8'h4F;
            4'd4: g = 8'h66;
            4'd5: g = 8'h6D;
            4'd6: g = 8'h7D;
            4'd7: g = 8'h07;
            4'd8: g = 8'h7F;
            4'd9: g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [8*SYMS-1:0] row5(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c, input logic [7:0] d,
                                                input logic [7:0] e);
        return {e, d, c, b, a};
    endfunction

    function automatic logic [8*SYMS-1:0] word_row(input logic [SID_W-1:0] id);
        logic [8*SYMS-1:0] r;
        case (id)
            5'd0:  r = row5(GBAR3, GBAR2, GLOW, GB, GB);
            5'd1:  r = row5(GC, GA, GL, GL, GB);
            5'd2:  r = row5(G1, GN, GF, G0, GB);
            5'd3:  r = row5(GU, SYM_DOT, GB, G1, GN);
            5'd4:  r = row5(GT, SYM_DOT, GR, GE, GG);
            5'd5:  r = row5(GU, SYM_DOT, G0, GF, GF);
            5'd6:  r = row5(G1, SYM_DOT, G0, GF, GF);
            5'd7:  r = row5(GU, SYM_DOT, GB, GH, G1);
            5'd8:  r = row5(G1, SYM_DOT, GB, GH, G1);
            5'd9:  r = row5(GB, GB, GB, GDEG, GB);
            5'd10: r = row5(GB, GB, GB, GB, GB);
            5'd11: r = row5(G0, GP, GE, GN, GB);
            5'd12: r = row5(G5, GH, GR, GT, GB);
            5'd13: r = row5(G0, GU, GT, GB, GB);
            5'd14: r = row5(GD, G0, GN, GE, GB);
            5'd15: r = row5(GF, GA, G1, GL, GB);
            5'd16: r = row5(GE, GB, GB, GB, GB);
            5'd17: r = row5(GF, GB, GB, GB, GB);
            5'd18: r = row5(GR, GU, GN, GB, GB);
            5'd19: r = row5(SYM_DOT, SYM_DOT, SYM_DOT, GB, GB);
            5'd20: r = row5(GU, SYM_DOT, GC, G0, GR);
            5'd21: r = row5(G1, SYM_DOT, GC, G0, GR);
            5'd22: r = row5(GC, G0, GR, GB, GB);
            5'd23: r = row5(GP, SYM_DOT, GB, G0, GN);
            5'd24: r = row5(GB, G0, GF, GF, GB);
            5'd25: r = row5(GL, GA, G5, GT, GB);
            5'd26: r = row5(GB, GB, G0, GN, GB);
            5'd27: r = row5(GB, GE, GR, GR, GB);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] word_len(input logic [SID_W-1:0] id);
        logic [2:0] n;
        case (id)
            5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd20, 5'd21, 5'd23: n = 3'd5;
            default: n = (id < SID_W'(WORDS)) ? 3'd4 : 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/seven_segment_display_formatter.sv -----
`default_nettype none

// Seven-segment display formatter with an internal buffer of display digits.
// A request is taken on a rising edge where start is high and busy is low; kind,
// number, word_sel and digit_position are sampled on that edge.
// Number requests convert the value to decimal with a shift-and-add-three unit
// that runs one bit per cycle, then write one digit per cycle.
// Word requests step through the word table one symbol per cycle.
// The done strobe is high for one cycle with the whole buffer on segments.
// A number request runs the conversion steps, writes its digits and hands
// the result off before the strobe. A word stops after its last symbol or
// after four written symbols. Busy falls in the strobe cycle, so a new
// request may be taken there; none is taken while busy.
// The receiver cannot stall; every result is flagged once, with done high for one cycle.
// Reset clears the buffer to blank, idles the sequencer and drops done.

module seven_segment_display_formatter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ssd_fmt_pkg::KIND_W-1:0]   kind,
    input  logic [ssd_fmt_pkg::NUM_W-1:0]    number,
    input  logic [ssd_fmt_pkg::SID_W-1:0]    word_sel,
    input  logic [ssd_fmt_pkg::DPOS_W-1:0]   digit_position,
    output logic                             done,
    output logic [ssd_fmt_pkg::SEG_W-1:0]    segments
);
    import ssd_fmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_DIGW,
        S_WORD,
        S_DOT,
        S_OUT
    } state_t;

    localparam int CNT_W = $clog2(NUM_W);

    state_t             state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [SID_W-1:0]   sid_reg, sid_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [NUM_W-1:0]   shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         dig_reg, dig_next;
    logic [2:0]         idx_reg, idx_next;
    logic [2:0]         written_reg, written_next;
    logic [7:0]         disp_reg [DIGITS];
    logic [7:0]         disp_next [DIGITS];
    logic               done_reg, done_next;
    logic [SEG_W-1:0]   segments_reg, segments_next;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         nib;
    logic [8*SYMS-1:0]  row;
    logic [7:0]         sym;
    logic [2:0]         len;
    logic [POS_W-1:0]   pos_m1;

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign segments = segments_reg;

    always_comb
    begin
        for (int d = 0; d < BCD_W / 4; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ? bcd_reg[4*d +: 4] + 4'd3
                                                            : bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        sid_next      = sid_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        dig_next      = dig_reg;
        idx_next      = idx_reg;
        written_next  = written_reg;
        done_next     = 1'b0;
        segments_next = segments_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            disp_next[i] = disp_reg[i];
        end

        nib = bcd_reg[{dig_reg, 2'b00} +: 4];
        if (kind_reg == KIND_NUM4 && bcd_reg[BCD_W-1 -: 4] != 4'd0)
        begin
            nib = 4'd9;
        end
        row    = word_row(sid_reg);
        len    = word_len(sid_reg);
        sym    = (idx_reg < 3'(SYMS)) ? row[{idx_reg, 3'b000} +: 8] : 8'h00;
        pos_m1 = pos_reg - POS_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = kind;
                    sid_next     = word_sel;
                    pos_next     = POS_W'(digit_position);
                    shift_next   = number;
                    bcd_next     = '0;
                    cnt_next     = '0;
                    idx_next     = '0;
                    written_next = '0;
                    if (kind inside {KIND_NUM4, KIND_NUM3, KIND_NUM2})
                    begin
                        state_next = S_CONV;
                    end
                    else if (kind == KIND_WORD)
                    begin
                        state_next = S_WORD;
                    end
                    else if (kind == KIND_DOT)
                    begin
                        state_next = S_DOT;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CONV:
            begin
                bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[NUM_W-1]};
                shift_next = {shift_reg[NUM_W-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = S_DIGW;
                    case (kind_reg)
                        KIND_NUM4: dig_next = 2'd3;
                        KIND_NUM3: dig_next = 2'd2;
                        default:   dig_next = 2'd1;
                    endcase
                end
            end
            S_DIGW:
            begin
                if (pos_reg < POS_W'(DIGITS))
                begin
                    disp_next[pos_reg[IDX_W-1:0]] = digit_glyph(nib);
                end
                pos_next = pos_reg + POS_W'(1);
                dig_next = dig_reg - 2'd1;
                if (dig_reg == 2'd0)
                begin
                    state_next = S_OUT;
                end
            end
            S_WORD:
            begin
                if (idx_reg < len && written_reg < 3'd4)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (sym == SYM_DOT)
                    begin
                        if (pos_reg != '0 && pos_m1 < POS_W'(DIGITS))
                        begin
                            disp_next[pos_m1[IDX_W-1:0]] =
                                disp_reg[pos_m1[IDX_W-1:0]] | SYM_DOT;
                        end
                    end
                    else
                    begin
                        if (pos_reg < POS_W'(DIGITS))
                        begin
                            disp_next[pos_reg[IDX_W-1:0]] = sym;
                        end
                        pos_next     = pos_reg + POS_W'(1);
                        written_next = written_reg + 3'd1;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DOT:
            begin
                if (pos_reg < POS_W'(DIGITS))
                begin
                    disp_next[pos_reg[IDX_W-1:0]] = disp_reg[pos_reg[IDX_W-1:0]] | SYM_DOT;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                segments_next = '0;
                for (int i = 0; i < OUT_SHOWN; i++)
                begin
                    segments_next[8*i +: 8] = disp_reg[i];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            dig_reg     <= '0;
            idx_reg     <= '0;
            written_reg <= '0;
            for (int i = 0; i < DIGITS; i++)
            begin
                disp_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            dig_reg     <= dig_next;
            idx_reg     <= idx_next;
            written_reg <= written_next;
            for (int i = 0; i < DIGITS; i++)
            begin
                disp_reg[i] <= disp_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sid_reg      <= sid_next;
        pos_reg      <= pos_next;
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        segments_reg <= segments_next;
    end

endmodule

`default_nettype wire

// ----- bench/seven_segment_display_formatter_tb.sv -----
`timescale 1ns / 1ps

module seven_segment_display_formatter_tb;

    localparam int KW = ssd_fmt_pkg::KIND_W;
    localparam int NW = ssd_fmt_pkg::NUM_W;
    localparam int SW = ssd_fmt_pkg::SID_W;
    localparam int PW = ssd_fmt_pkg::DPOS_W;
    localparam int OW = ssd_fmt_pkg::SEG_W;

    localparam int BUF_DIGITS = 8;
    localparam int WORD_COUNT = 28;
    localparam logic [7:0] DOT_SYM = 8'h80;
    localparam int RANDOM_REQUESTS = 750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [KW-1:0] kind;
    logic [NW-1:0] number;
    logic [SW-1:0] word_sel;
    logic [PW-1:0] digit_position;
    logic          done;
    logic [OW-1:0] segments;

    logic [7:0]    shadow_digits [0:BUF_DIGITS-1];
    logic [OW-1:0] pending_frames [$];
    logic [OW-1:0] wanted_frame;
    int            failure_count;
    int            cycle_count;

    seven_segment_display_formatter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .number         (number),
        .word_sel       (word_sel),
        .digit_position (digit_position),
        .done           (done),
        .segments       (segments)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] decimal_glyph(input int d);
        logic [7:0] g;
        begin
            case (d)
                0: g = 8'h3F;
                1: g = 8'h06;
                2: g = 8'h5B;
                3: g = 8'h4F;
                4: g = 8'h66;
                5: g = 8'h6D;
                6: g = 8'h7D;
                7: g = 8'h07;
                8: g = 8'h7F;
                default: g = 8'h6F;
            endcase
            return g;
        end
    endfunction

    // Symbols are packed first symbol in the top byte.
    function automatic logic [39:0] word_symbols(input int id);
        logic [39:0] r;
        begin
            case (id)
                0:  r = {8'h49, 8'h48, 8'h08, 8'h00, 8'h00};
                1:  r = {8'h39, 8'h77, 8'h38, 8'h38, 8'h00};
                2:  r = {8'h06, 8'h54, 8'h71, 8'h3F, 8'h00};
                3:  r = {8'h3E, DOT_SYM, 8'h00, 8'h06, 8'h54};
                4:  r = {8'h78, DOT_SYM, 8'h50, 8'h79, 8'h3D};
                5:  r = {8'h3E, DOT_SYM, 8'h3F, 8'h71, 8'h71};
                6:  r = {8'h06, DOT_SYM, 8'h3F, 8'h71, 8'h71};
                7:  r = {8'h3E, DOT_SYM, 8'h00, 8'h76, 8'h06};
                8:  r = {8'h06, DOT_SYM, 8'h00, 8'h76, 8'h06};
                9:  r = {8'h00, 8'h00, 8'h00, 8'h63, 8'h00};
                10: r = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
                11: r = {8'h3F, 8'h73, 8'h79, 8'h54, 8'h00};
                12: r = {8'h6D, 8'h76, 8'h50, 8'h78, 8'h00};
                13: r = {8'h3F, 8'h3E, 8'h78, 8'h00, 8'h00};
                14: r = {8'h7C, 8'h3F, 8'h54, 8'h79, 8'h00};
                15: r = {8'h71, 8'h77, 8'h06, 8'h38, 8'h00};
                16: r = {8'h79, 8'h00, 8'h00, 8'h00, 8'h00};
                17: r = {8'h71, 8'h00, 8'h00, 8'h00, 8'h00};
                18: r = {8'h50, 8'h3E, 8'h54, 8'h00, 8'h00};
                19: r = {DOT_SYM, DOT_SYM, DOT_SYM, 8'h00, 8'h00};
                20: r = {8'h3E, DOT_SYM, 8'h39, 8'h3F, 8'h50};
                21: r = {8'h06, DOT_SYM, 8'h39, 8'h3F, 8'h50};
                22: r = {8'h39, 8'h3F, 8'h50, 8'h00, 8'h00};
                23: r = {8'h73, DOT_SYM, 8'h00, 8'h3F, 8'h54};
                24: r = {8'h00, 8'h3F, 8'h71, 8'h71, 8'h00};
                25: r = {8'h38, 8'h77, 8'h6D, 8'h78, 8'h00};
                26: r = {8'h00, 8'h00, 8'h3F, 8'h54, 8'h00};
                default: r = {8'h00, 8'h79, 8'h50, 8'h50, 8'h00};
            endcase
            return r;
        end
    endfunction

    function automatic int word_length(input int id);
        begin
            case (id)
                3, 4, 5, 6, 7, 8, 20, 21, 23: return 5;
                default: return 4;
            endcase
        end
    endfunction

    task automatic place_digit(input int pos, input logic [7:0] seg);
        begin
            if (pos < BUF_DIGITS)
                shadow_digits[pos] = seg;
        end
    endtask

    task automatic place_dot(input int pos);
        begin
            if (pos < BUF_DIGITS)
                shadow_digits[pos] = shadow_digits[pos] | DOT_SYM;
        end
    endtask

    task automatic apply_request(input logic [KW-1:0] k, input logic [NW-1:0] n,
                                 input logic [SW-1:0] s, input logic [PW-1:0] p,
                                 output logic [OW-1:0] frame);
        int value;
        int count;
        int div;
        int pos;
        int written;
        int sym_idx;
        logic [39:0] syms;
        logic [7:0] sym;
        begin
            pos = int'(p);
            count = 0;
            value = int'(n);
            if (k == ssd_fmt_pkg::KIND_NUM4)
            begin
                count = 4;
                if (value > 9999)
                    value = 9999;
            end
            else if (k == ssd_fmt_pkg::KIND_NUM3)
            begin
                count = 3;
                value = value % 1000;
            end
            else if (k == ssd_fmt_pkg::KIND_NUM2)
            begin
                count = 2;
                value = value % 100;
            end
            else if (k == ssd_fmt_pkg::KIND_WORD)
            begin
                if (int'(s) < WORD_COUNT)
                begin
                    syms = word_symbols(int'(s));
                    written = 0;
                    for (sym_idx = 0; sym_idx < word_length(int'(s)) && written < 4;
                         sym_idx++)
                    begin
                        sym = syms[39 - 8 * sym_idx -: 8];
                        if (sym == DOT_SYM)
                        begin
                            if (pos > 0)
                                place_dot(pos - 1);
                        end
                        else
                        begin
                            place_digit(pos, sym);
                            pos++;
                            written++;
                        end
                    end
                end
            end
            else if (k == ssd_fmt_pkg::KIND_DOT)
            begin
                place_dot(pos);
            end

            div = 1;
            for (int i = 1; i < count; i++)
                div = div * 10;
            for (int i = 0; i < count; i++)
            begin
                place_digit(pos + i, decimal_glyph((value / div) % 10));
                div = div / 10;
            end

            frame = '0;
            for (int i = 0; i < BUF_DIGITS; i++)
                frame[8 * i +: 8] = shadow_digits[i];
        end
    endtask

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(8, 40);
        end
    endfunction

    task automatic send_request(input logic [KW-1:0] k, input logic [NW-1:0] n,
                                input logic [SW-1:0] s, input logic [PW-1:0] p,
                                input bit with_gaps);
        logic [OW-1:0] frame;
        int gap;
        begin
            start <= 1'b1;
            kind <= k;
            number <= n;
            word_sel <= s;
            digit_position <= p;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            apply_request(k, n, s, p, frame);
            pending_frames.push_back(frame);
            gap = with_gaps ? pick_gap() : 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic test_unknown_kinds();
        begin
            for (int k = int'(ssd_fmt_pkg::KIND_DOT) + 1; k < (1 << KW); k++)
                send_request(KW'(k), '1, '1, '1, 1'b1);
        end
    endtask

    task automatic test_number_formats();
        begin
            send_request(ssd_fmt_pkg::KIND_NUM4, 16'd0, '0, 3'd0, 1'b1);
            send_request(ssd_fmt_pkg::KIND_NUM4, 16'd9999, '0, 3'd4, 1'b1);
            send_request(ssd_fmt_pkg::KIND_NUM4, 16'hFFFF, '1, 3'd7, 1'b0);
            send_request(ssd_fmt_pkg::KIND_NUM4, 16'd10000, '0, 3'd2, 1'b1);
            send_request(ssd_fmt_pkg::KIND_NUM3, 16'hFFFF, '0, 3'd5, 1'b0);
            send_request(ssd_fmt_pkg::KIND_NUM3, 16'd999, '0, 3'd0, 1'b1);
            send_request(ssd_fmt_pkg::KIND_NUM2, 16'd0, '0, 3'd6, 1'b1);
            send_request(ssd_fmt_pkg::KIND_NUM2, 16'd12345, '0, 3'd7, 1'b1);
        end
    endtask

    task automatic test_fixed_words();
        begin
            send_request(ssd_fmt_pkg::KIND_WORD, '0, 5'd19, 3'd0, 1'b1);
            send_request(ssd_fmt_pkg::KIND_WORD, '0, 5'd3, 3'd1, 1'b0);
            send_request(ssd_fmt_pkg::KIND_WORD, '0, 5'd4, 3'd6, 1'b1);
            send_request(ssd_fmt_pkg::KIND_WORD, '1, 5'd27, 3'd4, 1'b1);
            send_request(ssd_fmt_pkg::KIND_WORD, '0, 5'd28, 3'd0, 1'b0);
            send_request(ssd_fmt_pkg::KIND_WORD, '0, 5'd31, 3'd3, 1'b1);
        end
    endtask

    task automatic test_decimal_points();
        begin
            send_request(ssd_fmt_pkg::KIND_DOT, '0, '0, 3'd0, 1'b1);
            send_request(ssd_fmt_pkg::KIND_DOT, '1, '1, 3'd7, 1'b1);
        end
    endtask

    task automatic test_random_requests();
        int sent;
        int r;
        logic [KW-1:0] k;
        logic [NW-1:0] n;
        logic [SW-1:0] s;
        bit with_gaps;
        begin
            sent = 0;
            with_gaps = 1'b1;
            while (sent < RANDOM_REQUESTS)
            begin
                if (sent % 50 == 0)
                    with_gaps = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) != 0)
                    k = KW'($urandom_range(0, int'(ssd_fmt_pkg::KIND_DOT)));
                else
                    k = KW'($urandom_range(int'(ssd_fmt_pkg::KIND_DOT) + 1, (1 << KW) - 1));
                r = $urandom_range(0, 3);
                case (r)
                    0: n = NW'($urandom());
                    1: n = NW'($urandom_range(0, 9999));
                    2: n = NW'($urandom_range(0, 999));
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0: n = 16'd0;
                            1: n = 16'd9999;
                            2: n = 16'd10000;
                            3: n = 16'hFFFF;
                            4: n = 16'd999;
                            5: n = 16'd1000;
                            6: n = 16'd99;
                            default: n = 16'd100;
                        endcase
                    end
                endcase
                if ($urandom_range(0, 99) < 85)
                    s = SW'($urandom_range(0, WORD_COUNT - 1));
                else
                    s = SW'($urandom_range(WORD_COUNT, (1 << SW) - 1));
                send_request(k, n, s, PW'($urandom_range(0, BUF_DIGITS - 1)), with_gaps);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_frames.size() == 0)
            begin
                failure_count++;
                if (failure_count <= 10)
                    $display("unexpected result: segments %h", segments);
            end
            else
            begin
                wanted_frame = pending_frames.pop_front();
                if (segments !== wanted_frame)
                begin
                    failure_count++;
                    if (failure_count <= 10)
                        $display("segments mismatch: expected %h actual %h",
                                 wanted_frame, segments);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        failure_count = 0;
        cycle_count = 0;
        for (int i = 0; i < BUF_DIGITS; i++)
            shadow_digits[i] = 8'h00;
        rst_n = 1'b0;
        start = 1'b0;
        kind = '0;
        number = '0;
        word_sel = '0;
        digit_position = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unknown_kinds();
        test_number_formats();
        test_fixed_words();
        test_decimal_points();
        test_random_requests();

        start <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failure_count == 0 && pending_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
